// ===== design/xrg_pkg.sv =====
// Package with the constants and request codes of the xoshiro256** range generator.
`default_nettype none

package xrg_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned HALF_W   = 32;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned NUM_WORDS = 4;
    localparam int unsigned IN_DATA_W = 3 * WORD_W;

    // splitmix64 constants
    localparam logic [WORD_W-1:0] GOLDEN_INC = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [WORD_W-1:0] MIX_MUL_A  = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [WORD_W-1:0] MIX_MUL_B  = 64'h94d0_49bb_1331_11eb;

    // xoshiro256** shift and rotate amounts
    localparam int unsigned SHIFT_T = 17;
    localparam int unsigned ROT_S3  = 45;
    localparam int unsigned ROT_OUT = 7;

    // Request codes carried on the input tuser.
    localparam logic [REQ_W-1:0] REQ_RESEED = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RAW    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RANGE  = 2'd2;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned amt);
        logic [2*WORD_W-1:0] dbl;
        dbl = {v, v} << amt;
        return dbl[2*WORD_W-1:WORD_W];
    endfunction

endpackage

`default_nettype wire

// ===== design/xoshiro256ss_range_generator.sv =====
// Top level of the xoshiro256** generator with unbiased range reduction.
`default_nettype none

// The block holds a 256-bit xoshiro256** state and serves one request at a
// time; s_axis_tready is high only while it waits for a request. A reseed
// request (tuser 0) expands the 64-bit seed into four state words with four
// splitmix64 steps and returns nothing; each 64-bit product is built by the
// shared 32x32 multiplier. A raw request (tuser 1) returns one 64-bit draw.
// A range request (tuser 2) returns an unbiased value in [range_low,
// range_high]: each draw attempt runs the bit-serial restoring divider that
// forms the draw modulo the span, and a rejected draw starts a new attempt;
// at least half of all draws are accepted. When the span wraps to zero (the
// full 64-bit range) the raw draw is returned. Request code 3 is dropped
// without any effect. A finished result sits in the output register until
// the downstream side takes it; the next request is accepted meanwhile.
// After reset the state is all zero and every draw is zero until a reseed.
module xoshiro256ss_range_generator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata fields from bit 0 up: seed_value[63:0], range_low[63:0], range_high[63:0]
    input  wire logic [xrg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // tuser fields from bit 0 up: req_type[1:0]
    input  wire logic [xrg_pkg::REQ_W-1:0]          s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata fields from bit 0 up: rand_value[63:0]
    output logic [xrg_pkg::WORD_W-1:0]              m_axis_tdata
);

    localparam int unsigned W  = xrg_pkg::WORD_W;
    localparam int unsigned H  = xrg_pkg::HALF_W;
    localparam int unsigned NW = xrg_pkg::NUM_WORDS;
    localparam int unsigned WI = $clog2(NW);
    localparam int unsigned DC = $clog2(W);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_PRE,
        ST_MUL_A,
        ST_MIX_MID,
        ST_MUL_B,
        ST_MIX_POST,
        ST_SPAN,
        ST_DRAW,
        ST_SCRAM,
        ST_DIV,
        ST_CHECK,
        ST_ACCEPT,
        ST_EMIT
    } state_t;

    typedef logic [W-1:0] word_t;

    // Control registers
    state_t         state_reg, state_next;
    logic [1:0]     mul_cnt_reg, mul_cnt_next;
    logic [WI-1:0]  word_cnt_reg, word_cnt_next;
    logic [DC-1:0]  div_cnt_reg, div_cnt_next;
    logic           raw_mode_reg, raw_mode_next;
    logic           span_zero_reg, span_zero_next;
    logic           m_valid_reg, m_valid_next;
    word_t          gen_state_reg [NW];
    word_t          gen_state_next [NW];

    // Payload registers
    word_t          m_data_reg, m_data_next;
    word_t          ctr_reg, ctr_next;
    word_t          z_reg, z_next;
    word_t          acc_reg, acc_next;
    logic [2*H-1:0] prod_reg, prod_next;
    word_t          low_reg, low_next;
    word_t          high_reg, high_next;
    word_t          span_reg, span_next;
    word_t          t5_reg, t5_next;
    word_t          x_reg, x_next;
    word_t          dvd_reg, dvd_next;
    word_t          rem_reg, rem_next;
    word_t          base_reg, base_next;
    word_t          res_reg, res_next;

    // Shared datapath signals
    logic [H-1:0]   mul_op_a;
    logic [H-1:0]   mul_op_b;
    word_t          mul_const;
    word_t          acc_addend;
    word_t          ctr_inc;
    word_t          scram;
    word_t          rot5;
    logic [W:0]     div_trial;
    logic [W:0]     span_wide;
    logic [W:0]     reject_sum;
    logic           in_fire;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // The one multiplier: a 32x32 product of halves picked by the phase counter.
    // Phase 0 forms lo*lo, phase 1 lo*hi, phase 2 hi*lo; phases 1..3 accumulate.
    always_comb begin
        mul_const = (state_reg == ST_MUL_B) ? xrg_pkg::MIX_MUL_B : xrg_pkg::MIX_MUL_A;
        case (mul_cnt_reg)
            2'd0: begin
                mul_op_a = z_reg[H-1:0];
                mul_op_b = mul_const[H-1:0];
            end
            2'd1: begin
                mul_op_a = z_reg[H-1:0];
                mul_op_b = mul_const[W-1:H];
            end
            2'd2: begin
                mul_op_a = z_reg[W-1:H];
                mul_op_b = mul_const[H-1:0];
            end
            default: begin
                mul_op_a = '0;
                mul_op_b = '0;
            end
        endcase
        acc_addend = (mul_cnt_reg == 2'd1) ? prod_reg : {prod_reg[H-1:0], {H{1'b0}}};
    end

    assign ctr_inc   = ctr_reg + xrg_pkg::GOLDEN_INC;
    assign rot5      = xrg_pkg::rotl(t5_reg, xrg_pkg::ROT_OUT);
    assign scram     = rot5 + {rot5[W-4:0], 3'b000};
    assign div_trial = {rem_reg, dvd_reg[W-1]};
    assign span_wide = {1'b0, span_reg};
    assign reject_sum = {1'b0, base_reg} + span_wide;

    always_comb begin
        state_next     = state_reg;
        mul_cnt_next   = mul_cnt_reg;
        word_cnt_next  = word_cnt_reg;
        div_cnt_next   = div_cnt_reg;
        raw_mode_next  = raw_mode_reg;
        span_zero_next = span_zero_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        gen_state_next = gen_state_reg;
        ctr_next       = ctr_reg;
        z_next         = z_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        span_next      = span_reg;
        t5_next        = t5_reg;
        x_next         = x_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        base_next      = base_reg;
        res_next       = res_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    ctr_next      = s_axis_tdata[W-1:0];
                    low_next      = s_axis_tdata[2*W-1:W];
                    high_next     = s_axis_tdata[3*W-1:2*W];
                    word_cnt_next = '0;
                    if (s_axis_tuser == xrg_pkg::REQ_RESEED) begin
                        state_next = ST_MIX_PRE;
                    end else if (s_axis_tuser == xrg_pkg::REQ_RAW) begin
                        raw_mode_next = 1'b1;
                        state_next    = ST_DRAW;
                    end else if (s_axis_tuser == xrg_pkg::REQ_RANGE) begin
                        raw_mode_next = 1'b0;
                        state_next    = ST_SPAN;
                    end
                end
            end
            // splitmix64: advance the counter and fold in the first shift.
            ST_MIX_PRE: begin
                ctr_next   = ctr_inc;
                z_next     = ctr_inc ^ (ctr_inc >> 30);
                state_next = ST_MUL_A;
            end
            ST_MUL_A, ST_MUL_B: begin
                prod_next    = (2*H)'(mul_op_a) * (2*H)'(mul_op_b);
                mul_cnt_next = mul_cnt_reg + 2'd1;
                if (mul_cnt_reg == 2'd0) begin
                    acc_next = '0;
                end else begin
                    acc_next = acc_reg + acc_addend;
                end
                if (mul_cnt_reg == 2'd3) begin
                    state_next = (state_reg == ST_MUL_A) ? ST_MIX_MID : ST_MIX_POST;
                end
            end
            ST_MIX_MID: begin
                z_next     = acc_reg ^ (acc_reg >> 27);
                state_next = ST_MUL_B;
            end
            ST_MIX_POST: begin
                gen_state_next[word_cnt_reg] = acc_reg ^ (acc_reg >> 31);
                word_cnt_next = word_cnt_reg + 1'b1;
                state_next    = (word_cnt_reg == WI'(NW - 1)) ? ST_IDLE : ST_MIX_PRE;
            end
            ST_SPAN: begin
                span_next      = high_reg - low_reg + 1'b1;
                span_zero_next = (high_reg - low_reg + 1'b1) == '0;
                state_next     = ST_DRAW;
            end
            // One xoshiro256** step; the multiply by five is a shift and add.
            ST_DRAW: begin
                t5_next = gen_state_reg[1] + {gen_state_reg[1][W-3:0], 2'b00};
                gen_state_next[2] = gen_state_reg[2] ^ gen_state_reg[0];
                gen_state_next[3] = gen_state_reg[3] ^ gen_state_reg[1];
                gen_state_next[1] = gen_state_reg[1] ^ gen_state_next[2];
                gen_state_next[0] = gen_state_reg[0] ^ gen_state_next[3];
                gen_state_next[2] = gen_state_next[2] ^
                                    (gen_state_reg[1] << xrg_pkg::SHIFT_T);
                gen_state_next[3] = xrg_pkg::rotl(gen_state_next[3], xrg_pkg::ROT_S3);
                state_next = ST_SCRAM;
            end
            ST_SCRAM: begin
                x_next       = scram;
                res_next     = scram;
                dvd_next     = scram;
                rem_next     = '0;
                div_cnt_next = '0;
                state_next   = (raw_mode_reg || span_zero_reg) ? ST_EMIT : ST_DIV;
            end
            // Restoring division, one dividend bit per cycle; only the remainder is kept.
            ST_DIV: begin
                dvd_next     = {dvd_reg[W-2:0], 1'b0};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_trial >= span_wide) begin
                    rem_next = W'(div_trial - span_wide);
                end else begin
                    rem_next = div_trial[W-1:0];
                end
                if (div_cnt_reg == DC'(W - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                base_next  = x_reg - rem_reg;
                state_next = ST_ACCEPT;
            end
            // The draw lies at or above the largest multiple of the span exactly
            // when the next multiple above its quotient no longer fits in 64 bits.
            ST_ACCEPT: begin
                if (reject_sum[W]) begin
                    state_next = ST_DRAW;
                end else begin
                    res_next   = low_reg + rem_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mul_cnt_reg   <= '0;
            word_cnt_reg  <= '0;
            div_cnt_reg   <= '0;
            raw_mode_reg  <= 1'b0;
            span_zero_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NW; i++) begin
                gen_state_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            mul_cnt_reg   <= mul_cnt_next;
            word_cnt_reg  <= word_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            raw_mode_reg  <= raw_mode_next;
            span_zero_reg <= span_zero_next;
            m_valid_reg   <= m_valid_next;
            gen_state_reg <= gen_state_next;
        end
        m_data_reg <= m_data_next;
        ctr_reg    <= ctr_next;
        z_reg      <= z_next;
        acc_reg    <= acc_next;
        prod_reg   <= prod_next;
        low_reg    <= low_next;
        high_reg   <= high_next;
        span_reg   <= span_next;
        t5_reg     <= t5_next;
        x_reg      <= x_next;
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        base_reg   <= base_next;
        res_reg    <= res_next;
    end

    // The multiplier phase counter is back at zero whenever no product is being built.
    a_mul_phase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_MUL_A && state_reg != ST_MUL_B) |-> mul_cnt_reg == 2'd0)
        else $error("multiplier phase counter left running");

    // The divider only runs for a nonzero span, and its remainder stays below it.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (!span_zero_reg && rem_reg < span_reg))
        else $error("divider remainder out of range");

    // An accepted draw is followed by the result stage; a rejected one by a new draw.
    a_accept_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCEPT) |=> (state_reg == ST_EMIT || state_reg == ST_DRAW))
        else $error("range check did not lead to a draw or a result");

endmodule

`default_nettype wire

// ===== dv/xrg_draw_checker.sv =====
// Checker that predicts every xoshiro256** draw and compares it with the result channel.
`timescale 1ns / 1ps

module xrg_draw_checker
    import xrg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    // tdata fields from bit 0 up: seed_value[63:0], range_low[63:0], range_high[63:0]
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    // tuser fields from bit 0 up: req_type[1:0]
    input  wire logic [REQ_W-1:0]       s_axis_tuser,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // tdata fields from bit 0 up: rand_value[63:0]
    input  wire logic [WORD_W-1:0]      m_axis_tdata,
    output int                          fail_count,
    output int                          pending
);

    localparam logic [WORD_W-1:0] ALL_ONES = '1;
    localparam int unsigned MAX_REPORTS = 10;

    logic [WORD_W-1:0] gen_words [NUM_WORDS];
    logic [WORD_W-1:0] expected_draws [$];
    int error_total = 0;

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic logic [WORD_W-1:0] rot_word(input logic [WORD_W-1:0] v,
                                                   input int unsigned n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    // One splitmix64 output mix on an already advanced counter.
    function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] ctr);
        logic [WORD_W-1:0] z;
        z = ctr;
        z = (z ^ (z >> 30)) * MIX_MUL_A;
        z = (z ^ (z >> 27)) * MIX_MUL_B;
        return z ^ (z >> 31);
    endfunction

    task automatic next_draw(output logic [WORD_W-1:0] draw_out);
        logic [WORD_W-1:0] t;
        draw_out = rot_word(gen_words[1] * 64'd5, ROT_OUT) * 64'd9;
        t = gen_words[1] << SHIFT_T;
        gen_words[2] = gen_words[2] ^ gen_words[0];
        gen_words[3] = gen_words[3] ^ gen_words[1];
        gen_words[1] = gen_words[1] ^ gen_words[2];
        gen_words[0] = gen_words[0] ^ gen_words[3];
        gen_words[2] = gen_words[2] ^ t;
        gen_words[3] = rot_word(gen_words[3], ROT_S3);
    endtask

    // Applies one accepted request to the predicted state and queues its draw, if any.
    task automatic draw_for_request(input logic [REQ_W-1:0] req,
                                    input logic [IN_DATA_W-1:0] data);
        logic [WORD_W-1:0] ctr, lo, hi, span, limit, x;
        ctr = data[WORD_W-1:0];
        lo = data[2*WORD_W-1:WORD_W];
        hi = data[3*WORD_W-1:2*WORD_W];
        case (req)
            REQ_RESEED: begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                    ctr = ctr + GOLDEN_INC;
                    gen_words[i] = mix_word(ctr);
                end
            end
            REQ_RAW: begin
                next_draw(x);
                expected_draws.push_back(x);
            end
            REQ_RANGE: begin
                span = hi - lo + 64'd1;
                if (span == '0) begin
                    // The whole 64-bit range: the draw goes out unchanged.
                    next_draw(x);
                    expected_draws.push_back(x);
                end else begin
                    limit = ALL_ONES - (ALL_ONES % span);
                    next_draw(x);
                    while (x >= limit) next_draw(x);
                    expected_draws.push_back(lo + (x % span));
                end
            end
            default: begin
                // The unused code is dropped without effect.
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        logic [WORD_W-1:0] want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_WORDS; i++) gen_words[i] = '0;
            expected_draws.delete();
        end else begin
            // Results are checked before new requests: no request yields a result at
            // the edge that accepts it.
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_draws.size() == 0) begin
                    if (error_total < MAX_REPORTS)
                        $display("%0t: result %h arrived with nothing expected",
                                 $realtime, m_axis_tdata);
                    error_total++;
                end else begin
                    want = expected_draws.pop_front();
                    if (m_axis_tdata !== want) begin
                        if (error_total < MAX_REPORTS)
                            $display("%0t: rand_value mismatch, expected %h, got %h",
                                     $realtime, want, m_axis_tdata);
                        error_total++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                draw_for_request(s_axis_tuser, s_axis_tdata);
        end
        pending <= expected_draws.size();
        fail_count <= error_total;
    end

endmodule

// ===== dv/tb_xoshiro256ss_range_generator.sv =====
// Testbench top for the xoshiro256** range generator: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_xoshiro256ss_range_generator;
    import xrg_pkg::*;

    // The block leaves code 3 unused; it must be dropped without effect.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic [WORD_W-1:0] ALL_ONES = '1;
    localparam logic [WORD_W-1:0] TOP_BIT  = 64'h8000_0000_0000_0000;

    // Random requests that actually do something; dropped ones are not counted.
    localparam int RANDOM_ITEMS = 750;
    localparam int QUIET_FROM   = 300;
    localparam int QUIET_TO     = 420;
    localparam int PAUSE_AT     = 420;
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 700;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // Settling time after the last result, since a reseed runs without a result.
    localparam int DRAIN_CYCLES = 200;

    logic aclk;
    logic aresetn = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
    logic [REQ_W-1:0]     s_axis_tuser  = REQ_RESEED;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WORD_W-1:0]    m_axis_tdata;

    int fail_count;
    int pending;

    // Idling controls. The sender reads tx_idle_en in its own process; the
    // receiver reads rx_idle_en and rx_hold_go, which are written with
    // nonblocking assignments so the receiver always sees a settled value.
    bit tx_idle_en = 1'b1;
    logic rx_idle_en = 1'b1;
    logic rx_hold_go = 1'b0;

    int unsigned cycle_count = 0;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    xoshiro256ss_range_generator uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    xrg_draw_checker draw_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_xoshiro256ss_range_generator: done, errors");
            $finish;
        end
    end

    // Receiver. It normally drops tready about 16 percent of the time. Once the
    // stimulus raises rx_hold_go it holds tready low without a break for the
    // length set by HOLD_CYCLES, counted here, so that a finished draw parks in
    // the output register, the next request runs behind it, and the block stops accepting requests.
    initial begin : receiver
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (rx_hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !rx_idle_en || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offers one request and returns at the edge that accepts it. tvalid stays
    // high afterwards, so the caller either offers the next request or lowers it.
    // Idle cycles are inserted at random ahead of the offer.
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [WORD_W-1:0] seed,
                                input logic [WORD_W-1:0] lo,
                                input logic [WORD_W-1:0] hi);
        while (tx_idle_en && $urandom_range(0, 99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {hi, lo, seed};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // Lowers tvalid and waits until every queued draw has come back. The extra
    // edge lets the checker record the request accepted at the current edge.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    initial begin : stimulus
        logic [REQ_W-1:0]  req;
        logic [WORD_W-1:0] seed, lo, hi;
        int issued;
        int pick;
        bit paused;
        bit hold_started;

        issued = 0;
        paused = 1'b0;
        hold_started = 1'b0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Before any reseed the state is all zero, so raw draws
        // are zero and a range request returns its lower bound.
        send_request(REQ_RAW,    rand_word(), rand_word(), rand_word());
        send_request(REQ_RANGE,  rand_word(), 64'd5, 64'd10);
        send_request(REQ_UNUSED, ALL_ONES, ALL_ONES, ALL_ONES);
        send_request(REQ_RANGE,  '0, ALL_ONES, ALL_ONES);
        // Seed of zero, then plain draws.
        send_request(REQ_RESEED, '0, rand_word(), rand_word());
        send_request(REQ_RAW,    ALL_ONES, '0, '0);
        send_request(REQ_RAW,    '0, ALL_ONES, ALL_ONES);
        // An ignored request between draws must not disturb the sequence.
        send_request(REQ_UNUSED, '0, '0, '0);
        send_request(REQ_RAW,    rand_word(), rand_word(), rand_word());
        send_request(REQ_RESEED, ALL_ONES, '0, '0);
        // Full span in both forms: [0, max] and a high bound just below the low.
        send_request(REQ_RANGE,  rand_word(), '0, ALL_ONES);
        send_request(REQ_RANGE,  rand_word(), 64'd123, 64'd122);
        // Single-value spans at both ends.
        send_request(REQ_RANGE,  rand_word(), ALL_ONES, ALL_ONES);
        send_request(REQ_RANGE,  rand_word(), '0, '0);
        // Low above high: the span wraps to two, the result wraps past the top.
        send_request(REQ_RANGE,  rand_word(), ALL_ONES, '0);
        // Spans at and just above half the range: close to half of all draws rejected.
        send_request(REQ_RANGE,  rand_word(), '0, TOP_BIT);
        send_request(REQ_RANGE,  rand_word(), 64'd77, TOP_BIT + 64'd79);
        send_request(REQ_RANGE,  rand_word(), '0, TOP_BIT - 64'd1);
        send_request(REQ_RESEED, rand_word(), rand_word(), rand_word());
        send_request(REQ_RANGE,  rand_word(), ALL_ONES - 64'd5, ALL_ONES);
        send_request(REQ_RANGE,  rand_word(), TOP_BIT, TOP_BIT - 64'd2);
        send_request(REQ_RAW,    rand_word(), rand_word(), rand_word());

        // Random part.
        while (issued < RANDOM_ITEMS) begin
            // A long stretch with neither side idling.
            tx_idle_en = !(issued >= QUIET_FROM && issued < QUIET_TO);
            rx_idle_en <= !(issued >= QUIET_FROM && issued < QUIET_TO);

            if (issued == PAUSE_AT && !paused) begin
                paused = 1'b1;
                wait_for_drain();
            end
            if (issued == HOLD_AT && !hold_started) begin
                hold_started = 1'b1;
                rx_hold_go <= 1'b1;
            end

            seed = rand_word();
            lo = rand_word();
            hi = rand_word();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                req = REQ_RESEED;
            end else if (pick < 38) begin
                req = REQ_RAW;
            end else if (pick < 93) begin
                req = REQ_RANGE;
                case ($urandom_range(0, 9))
                    0, 1, 2: hi = lo + 64'($urandom_range(0, 1000));
                    3: begin
                        lo = 64'($urandom_range(0, 50));
                        hi = lo + 64'($urandom_range(0, 20));
                    end
                    4, 5: begin
                        // Independent bounds; low lands above high about half the time.
                    end
                    6: hi = lo - 64'd1;
                    7: hi = lo + TOP_BIT + 64'($urandom_range(0, 3));
                    8: hi = lo + ((64'd1 << $urandom_range(0, 63)) - 64'd1);
                    default: begin
                        lo = '0;
                        hi = hi >> $urandom_range(0, 63);
                    end
                endcase
            end else begin
                req = REQ_UNUSED;
            end

            send_request(req, seed, lo, hi);
            if (req != REQ_UNUSED) issued++;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb_xoshiro256ss_range_generator: done, clean");
        end else begin
            $display("tb_xoshiro256ss_range_generator: done, errors");
        end
        $finish;
    end

endmodule
